>>> sv/fsk4bd_pkg.sv
// fsk4bd_pkg: types, constants and symbol functions shared by the
// 4-fsk block deinterleaver modules; no dependencies
`default_nettype none

package fsk4bd_pkg;

    localparam int SYM_BYTE_W   = 8;
    localparam int CW_W         = 32;
    localparam int BLK_W        = 4;
    localparam int CWN_W        = 3;
    localparam int PHASE_W      = 2;
    localparam int NUM_PHASES   = 4;
    localparam int CW_PER_PHASE = 8;
    localparam int NUM_CW       = NUM_PHASES * CW_PER_PHASE;
    localparam int CW_IDX_W     = $clog2(NUM_CW);
    localparam int BYTE_CNT_W   = 7;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 48;

    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE   = 7'd127;
    localparam logic [CW_IDX_W-1:0]   LAST_CW_IDX = 5'd31;

    typedef enum logic
    {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    typedef struct packed
    {
        logic accept;
        logic load;
    } cmd_t;

    typedef struct packed
    {
        logic block_done;
        logic emit_last;
        logic out_free;
    } sts_t;

    // remap swaps 0 and 1: high phase bit is the raw high bit
    function automatic logic sym_hi(input logic [1:0] sym);
        return sym[1];
    endfunction

    // remapped value is 1 or 2 exactly when the raw low bit is 0
    function automatic logic sym_mid(input logic [1:0] sym);
        return ~sym[0];
    endfunction

endpackage

`default_nettype wire

>>> sv/fsk4bd_ctrl.sv
// fsk4bd_ctrl: collect/emit state machine of the block deinterleaver
// depends on fsk4bd_pkg
`default_nettype none

module fsk4bd_ctrl
    import fsk4bd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (s_tvalid && sts.block_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EMIT:
            begin
                cmd.load = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/fsk4bd_datapath.sv
// fsk4bd_datapath: codeword shift store, byte and block counters and
// output register; depends on fsk4bd_pkg
`default_nettype none

module fsk4bd_datapath
    import fsk4bd_pkg::*;
#(
    parameter int BLOCKS_PER_FRAME = 11
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [SYM_BYTE_W-1:0]  symbol_byte,
    input  wire logic                   frame_start,
    input  wire cmd_t                   cmd,
    output sts_t                        sts,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [PHASE_W-1:0]          out_phase,
    output logic [BLK_W-1:0]            out_block,
    output logic [CWN_W-1:0]            out_cwn,
    output logic [CW_W-1:0]             out_codeword,
    output logic                        out_last
);

    localparam logic [BLK_W:0] BPF = (BLK_W+1)'(BLOCKS_PER_FRAME);

    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [CW_IDX_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic [CW_W-1:0]       store_reg [NUM_CW];
    logic                  out_valid_reg, out_valid_next;
    logic [PHASE_W-1:0]    out_phase_reg;
    logic [BLK_W-1:0]      out_block_reg;
    logic [CWN_W-1:0]      out_cwn_reg;
    logic [CW_W-1:0]       out_codeword_reg;
    logic                  out_last_reg;

    logic [BYTE_CNT_W-1:0] eff_cnt;
    logic [BLK_W-1:0]      eff_blk;
    logic [BLK_W:0]        blk_inc;
    logic [CWN_W-1:0]      cw0;
    logic [CWN_W-1:0]      cw1;
    logic [NUM_CW-1:0]     shift_en;
    logic [NUM_CW-1:0]     new_bit;

    assign eff_cnt = frame_start ? '0 : byte_cnt_reg;
    assign eff_blk = frame_start ? '0 : blk_reg;
    assign blk_inc = {1'b0, blk_reg} + (BLK_W+1)'(1);
    assign cw0     = {eff_cnt[1:0], 1'b0};
    assign cw1     = {eff_cnt[1:0], 1'b1};

    assign sts.block_done = (eff_cnt == LAST_BYTE);
    assign sts.emit_last  = (emit_cnt_reg == LAST_CW_IDX);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // per entry: does this byte write it, and with which bit
    always_comb
    begin
        logic [PHASE_W-1:0] ph;
        logic [CWN_W-1:0]   cw;
        logic [1:0]         sym;
        for (int i = 0; i < NUM_CW; i++)
        begin
            ph  = PHASE_W'(i / CW_PER_PHASE);
            cw  = CWN_W'(i % CW_PER_PHASE);
            if (cw == cw0)
            begin
                sym = ph[1] ? symbol_byte[5:4] : symbol_byte[7:6];
            end
            else
            begin
                sym = ph[1] ? symbol_byte[1:0] : symbol_byte[3:2];
            end
            new_bit[i]  = ph[0] ? sym_mid(sym) : sym_hi(sym);
            shift_en[i] = cmd.accept && ((cw == cw0) || (cw == cw1));
        end
    end

    // bits arrive in bit order 0..31, so each entry shifts in from the top
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_CW; i++)
        begin
            if (shift_en[i])
            begin
                store_reg[i] <= {new_bit[i], store_reg[i][CW_W-1:1]};
            end
        end
    end

    always_comb
    begin
        byte_cnt_next  = byte_cnt_reg;
        blk_next       = blk_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.accept)
        begin
            byte_cnt_next = eff_cnt + BYTE_CNT_W'(1);
            blk_next      = eff_blk;
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            emit_cnt_next  = emit_cnt_reg + CW_IDX_W'(1);
            if (sts.emit_last)
            begin
                blk_next = (blk_inc >= BPF) ? '0 : blk_inc[BLK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg  <= '0;
            blk_reg       <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byte_cnt_reg  <= byte_cnt_next;
            blk_reg       <= blk_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_phase_reg    <= emit_cnt_reg[CW_IDX_W-1:CWN_W];
            out_block_reg    <= blk_reg;
            out_cwn_reg      <= emit_cnt_reg[CWN_W-1:0];
            out_codeword_reg <= store_reg[emit_cnt_reg];
            out_last_reg     <= sts.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_phase    = out_phase_reg;
    assign out_block    = out_block_reg;
    assign out_cwn      = out_cwn_reg;
    assign out_codeword = out_codeword_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

>>> sv/fsk4_symbol_block_deinterleaver_unit.sv
// fsk4_symbol_block_deinterleaver_unit: top level of the 4-fsk block
// deinterleaver; depends on fsk4bd_pkg, fsk4bd_ctrl, fsk4bd_datapath
`default_nettype none

// Each input transfer carries one byte of four 2-bit symbols (bits 7:6 first)
// and a frame-start flag in s_tuser that restarts the block and sets the block
// index to 0. One byte is taken per cycle while a block is being collected.
// The 128th byte of a block starts the readout: 32 codewords leave in phase
// order A, B, C, D, codewords 0..7 within each phase, one per cycle through
// the single output register while m_tready is high, and s_tready stays low
// until the readout is done. The readout rate is set by the one stored
// codeword read per cycle. m_tlast marks the last codeword of a block.

module fsk4_symbol_block_deinterleaver_unit
    import fsk4bd_pkg::*;
#(
    parameter int BLOCKS_PER_FRAME = 11
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // symbol_byte[7:0]
    input  wire logic                   s_tuser,   // frame_start
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // phase[1:0], block_number[5:2],
                                                   // codeword_number[8:6],
                                                   // codeword[40:9], zero[47:41]
    output logic                        m_tlast    // last_of_block
);

    localparam int PAD_W = OUT_TDATA_W - PHASE_W - BLK_W - CWN_W - CW_W;

    cmd_t               cmd;
    sts_t               sts;
    logic [PHASE_W-1:0] out_phase;
    logic [BLK_W-1:0]   out_block;
    logic [CWN_W-1:0]   out_cwn;
    logic [CW_W-1:0]    out_codeword;

    fsk4bd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsk4bd_datapath #(
        .BLOCKS_PER_FRAME (BLOCKS_PER_FRAME)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol_byte  (s_tdata[SYM_BYTE_W-1:0]),
        .frame_start  (s_tuser),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_phase    (out_phase),
        .out_block    (out_block),
        .out_cwn      (out_cwn),
        .out_codeword (out_codeword),
        .out_last     (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_codeword, out_cwn, out_block, out_phase};

endmodule

`default_nettype wire

>>> sv/fsk4bd_checker.sv
// fsk4bd_checker: port-level assertions for the block deinterleaver and
// the bind that attaches them; depends on fsk4bd_pkg and the top level
`default_nettype none

module fsk4bd_checker
    import fsk4bd_pkg::*;
#(
    parameter int BLOCKS_PER_FRAME = 11
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   m_tlast
);

    // last codeword of a block is phase d, codeword 7
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[1:0] == 2'd3 && m_tdata[8:6] == 3'd7))
        else $error("tlast on a codeword other than the last of the block");

    // input is held off while a block readout is under way
    a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input ready during block readout");

    // block index stays inside the frame
    a_block_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[5:2]} < 5'(BLOCKS_PER_FRAME)))
        else $error("block number out of range");

    // a stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");

endmodule

bind fsk4_symbol_block_deinterleaver_unit fsk4bd_checker #(
    .BLOCKS_PER_FRAME (BLOCKS_PER_FRAME)
) u_fsk4bd_checker (.*);

`default_nettype wire

>>> test/tb_fsk4_symbol_block_deinterleaver_unit.sv
// tb_fsk4_symbol_block_deinterleaver_unit: self-checking bench for the 4-fsk block
// deinterleaver; predicts every codeword readout from the accepted symbol bytes
// depends on fsk4bd_pkg and fsk4_symbol_block_deinterleaver_unit
`timescale 1ns / 1ps

module tb_fsk4_symbol_block_deinterleaver_unit;

    import fsk4bd_pkg::*;

    localparam int BLOCKS_PER_FRAME = 11;
    localparam int BYTES_PER_BLOCK  = 128;
    localparam int HOLD_CYCLES      = 300;
    localparam int MAX_REPORTS      = 100;

    typedef enum logic [PHASE_W-1:0]
    {
        PH_A,
        PH_B,
        PH_C,
        PH_D
    } cw_phase_t;

    typedef struct packed
    {
        cw_phase_t          phase;
        logic [BLK_W-1:0]   blk_num;
        logic [CWN_W-1:0]   cw_num;
        logic [CW_W-1:0]    word;
        logic               last_cw;
    } codeword_exp_t;

    // frame_start, symbol byte
    localparam logic [8:0] DIRECTED_ROWS [0:23] = '{
        9'h000, 9'h0FF, 9'h01B, 9'h0E4, 9'h055, 9'h0AA, 9'h0FF, 9'h000,
        9'h10F, 9'h0F0, 9'h033, 9'h0CC, 9'h066, 9'h099, 9'h11B, 9'h0E4,
        9'h080, 9'h001, 9'h17E, 9'h081, 9'h100, 9'h1FF, 9'h0C3, 9'h03C
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;      // symbol_byte[7:0]
    logic                   s_tuser = 1'b0;    // frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // phase[1:0], block_number[5:2],
                                               // codeword_number[8:6], codeword[40:9]
    logic                   m_tlast;           // last_of_block

    logic [7:0]             pair_pos;
    logic [BLK_W-1:0]       blk_idx;
    logic [CW_W-1:0]        cw_store [NUM_CW];
    codeword_exp_t          cw_expected [$];

    int                     mismatches = 0;
    int                     codewords_taken = 0;
    bit                     calm_stretch = 1'b0;
    bit                     hold_done = 1'b0;

    fsk4_symbol_block_deinterleaver_unit
    #(
        .BLOCKS_PER_FRAME(BLOCKS_PER_FRAME)
    )
    DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // deinterleave one byte into the codeword store, queue the block when complete
    task automatic deinterleave_byte(input logic [7:0] sym_byte, input logic frame_start);
        logic [1:0]    sym;
        logic [7:0]    pr;
        int            base;
        logic          hi;
        logic          mid;
        codeword_exp_t e;
        if (frame_start)
        begin
            pair_pos = '0;
            blk_idx  = '0;
        end
        for (int k = 0; k < 4; k++)
        begin
            sym  = sym_byte[7 - 2 * k -: 2];
            pr   = pair_pos + 8'(k >> 1);
            base = (k % 2 == 1) ? int'(PH_C) : int'(PH_A);
            if (!sym[1])
            begin
                sym[0] = ~sym[0];
            end
            hi  = (sym >= 2'd2);
            mid = (sym == 2'd1) || (sym == 2'd2);
            cw_store[base * CW_PER_PHASE + pr[2:0]][pr[7:3]] = hi;
            cw_store[(base + 1) * CW_PER_PHASE + pr[2:0]][pr[7:3]] = mid;
        end
        pair_pos = pair_pos + 8'd2;
        if (pair_pos == 8'd0)
        begin
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                for (int c = 0; c < CW_PER_PHASE; c++)
                begin
                    e.phase   = cw_phase_t'(p);
                    e.blk_num = blk_idx;
                    e.cw_num  = CWN_W'(c);
                    e.word    = cw_store[p * CW_PER_PHASE + c];
                    e.last_cw = (p == NUM_PHASES - 1) && (c == CW_PER_PHASE - 1);
                    cw_expected.push_back(e);
                end
            end
            if (int'(blk_idx) + 1 >= BLOCKS_PER_FRAME)
            begin
                blk_idx = '0;
            end
            else
            begin
                blk_idx = blk_idx + 1'b1;
            end
        end
    endtask

    task automatic send_sym_byte(input logic [7:0] sym_byte, input logic frame_start);
        if (!calm_stretch && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym_byte;
        s_tuser  <= frame_start;
        do
            @(posedge clk);
        while (!s_tready);
        deinterleave_byte(sym_byte, frame_start);
    endtask

    // receiver: random stalls, one long hold-off during a readout
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && m_tvalid && codewords_taken >= 8)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= calm_stretch || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        codeword_exp_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            codewords_taken++;
            if (cw_expected.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected codeword transfer, tdata %h", m_tdata));
            end
            else
            begin
                e = cw_expected.pop_front();
                if (m_tdata[1:0] != e.phase)
                    flag_mismatch($sformatf("phase %0d, want %0d", m_tdata[1:0], e.phase));
                if (m_tdata[5:2] != e.blk_num)
                    flag_mismatch($sformatf("block %0d, want %0d", m_tdata[5:2], e.blk_num));
                if (m_tdata[8:6] != e.cw_num)
                    flag_mismatch($sformatf("codeword number %0d, want %0d",
                                            m_tdata[8:6], e.cw_num));
                if (m_tdata[40:9] != e.word)
                    flag_mismatch($sformatf("codeword %h, want %h (phase %0d, number %0d)",
                                            m_tdata[40:9], e.word, e.phase, e.cw_num));
                if (m_tlast != e.last_cw)
                    flag_mismatch($sformatf("tlast %0b, want %0b", m_tlast, e.last_cw));
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int nbytes;
        pair_pos = '0;
        blk_idx  = '0;
        for (int i = 0; i < NUM_CW; i++)
        begin
            cw_store[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            send_sym_byte(DIRECTED_ROWS[i][7:0], DIRECTED_ROWS[i][8]);
        end

        // first frame is cut mid-block by the next frame start, the second ends on a block edge
        for (int f = 0; f < 2; f++)
        begin
            nbytes = BYTES_PER_BLOCK + ((f == 0) ? $urandom_range(20, 4) : 0);
            for (int i = 0; i < nbytes; i++)
            begin
                calm_stretch = (f == 0) && (i >= 20) && (i < 100);
                send_sym_byte(8'($urandom_range(255, 0)), i == 0);
            end
        end
        calm_stretch = 1'b0;
        s_tvalid <= 1'b0;

        while (cw_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/fsk4bd_pkg.sv
sv/fsk4bd_ctrl.sv
sv/fsk4bd_datapath.sv
sv/fsk4_symbol_block_deinterleaver_unit.sv
sv/fsk4bd_checker.sv
test/tb_fsk4_symbol_block_deinterleaver_unit.sv
